### rtl/core/iee_pkg.sv
package iee_pkg;

    // Default configuration
    localparam int DEF_STACK_DEPTH         = 16;
    localparam int DEF_VALUE_WIDTH         = 48;
    localparam int DEF_FRAC_BITS           = 16;
    localparam int DEF_MAX_FRACTION_DIGITS = 6;

    // Width of the power-of-ten table entries (10^9 < 2^30)
    localparam int P10W = 30;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_LEADING  = 3'd1;
    localparam logic [2:0] ST_DOUBLE   = 3'd2;
    localparam logic [2:0] ST_TRAILING = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;
    localparam logic [2:0] ST_DIVZERO  = 3'd5;

    // Operator codes, also their priority order
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Character codes
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_STAR  = 8'd42;
    localparam logic [7:0] CH_SLASH = 8'd47;
    localparam logic [7:0] CH_POINT = 8'd46;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    // Arithmetic unit commands
    typedef enum logic [2:0] {
        CMD_ADD  = 3'd0,
        CMD_SUB  = 3'd1,
        CMD_MUL  = 3'd2,
        CMD_DIV  = 3'd3,
        CMD_FDIV = 3'd4
    } t_alu_cmd;

    typedef struct packed {
        logic     start;
        t_alu_cmd cmd;
    } t_alu_req;

    // Power-of-ten table
    function automatic logic [P10W-1:0] pow10(input int n);
        logic [P10W-1:0] p;
        case (n)
            0:       p = P10W'(1);
            1:       p = P10W'(10);
            2:       p = P10W'(100);
            3:       p = P10W'(1000);
            4:       p = P10W'(10000);
            5:       p = P10W'(100000);
            6:       p = P10W'(1000000);
            7:       p = P10W'(10000000);
            8:       p = P10W'(100000000);
            9:       p = P10W'(1000000000);
            default: p = P10W'(1);
        endcase
        return p;
    endfunction

endpackage

### rtl/core/iee_if.sv
interface iee_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface iee_result_if #(parameter int VW = 48);
    logic                 valid;
    logic                 ready;
    logic signed [VW-1:0] result_value;
    logic [2:0]           status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface

### rtl/core/infix_expression_evaluator.sv
// Digit, point and ignored characters: ready again the next cycle.
// Operator: the number is converted and pushed, each reduction runs in the shared unit (multiply,
// divide and fraction conversion are bit-serial), then the operator is pushed and ready returns.
// Last character: the same conversion and reductions; the result then waits in an output register,
// and ready follows its transfer.
// Synchronous active-low reset clears counts and number state; stack contents are kept.
module infix_expression_evaluator
    import iee_pkg::*;
#(
    parameter int STACK_DEPTH         = DEF_STACK_DEPTH,
    parameter int VALUE_WIDTH         = DEF_VALUE_WIDTH,
    parameter int FRAC_BITS           = DEF_FRAC_BITS,
    parameter int MAX_FRACTION_DIGITS = DEF_MAX_FRACTION_DIGITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    iee_char_if.sink      i_char,
    iee_result_if.source  o_result
);

    localparam int W    = VALUE_WIDTH;
    localparam int IW   = W - 1 - FRAC_BITS;
    localparam int FDW  = $clog2(pow10(MAX_FRACTION_DIGITS));
    localparam int FCW  = $clog2(MAX_FRACTION_DIGITS + 1);
    localparam int NW_D = W + FRAC_BITS;
    localparam int NW_F = FDW + FRAC_BITS + 1;
    localparam int NW   = (NW_D > NW_F) ? NW_D : NW_F;
    localparam int DVW  = (W > FDW) ? W : FDW;
    localparam int CW   = $clog2(STACK_DEPTH + 1);
    localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_NUM    = 10'b0000000010,
        S_NUMW   = 10'b0000000100,
        S_RD     = 10'b0000001000,
        S_TEST   = 10'b0000010000,
        S_OPW    = 10'b0000100000,
        S_PUSHOP = 10'b0001000000,
        S_FIN    = 10'b0010000000,
        S_OUT    = 10'b0100000000,
        S_SPARE  = 10'b1000000000
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_vcnt, n_vcnt;
    logic [CW-1:0]       r_ocnt, n_ocnt;
    logic [IW-1:0]       r_int, n_int;
    logic [FDW-1:0]      r_frac, n_frac;
    logic [FCW-1:0]      r_fcnt, n_fcnt;
    logic                r_point, n_point;
    logic                r_after_op, n_after_op;
    logic [2:0]          r_err, n_err;
    logic                r_last, n_last;
    logic                r_final, n_final;
    logic [1:0]          r_pend_op, n_pend_op;
    logic signed [W-1:0] r_out_value, n_out_value;
    logic [2:0]          r_out_status, n_out_status;

    // Stacks and their registered read data
    logic [W-1:0]        r_vmem [STACK_DEPTH];
    logic [1:0]          r_omem [STACK_DEPTH];
    logic [W-1:0]        r_rd_a, r_rd_b;
    logic [1:0]          r_rd_op;

    logic                v_we, o_we;
    logic [AW-1:0]       v_waddr, o_waddr;
    logic [W-1:0]        v_wdata;
    logic [CW-1:0]       vm1, vm2, om1;

    // Character decode
    logic                accept, is_op, is_digit, is_point;
    logic [1:0]          opc;
    logic [3:0]          dig;
    logic [IW+3:0]       int_nx;
    logic [FDW+3:0]      frac_nx;

    // Number conversion
    logic [DVW-1:0]      pw;
    logic [NW-1:0]       frac_num;
    logic [W-1:0]        fpart;
    logic [W:0]          total;

    // Shared unit
    t_alu_req            alu_req;
    logic signed [W-1:0] alu_a, alu_b, alu_res;
    logic                alu_done;

    // Reduction operands
    logic [W-1:0]        op_a, op_b;
    logic [CW-1:0]       vcnt_pop;
    logic [2:0]          err_t;

    assign accept = i_char.valid && i_char.ready;

    always_comb begin
        is_op = 1'b1;
        opc   = OP_ADD;
        case (i_char.char_code)
            CH_PLUS:  opc = OP_ADD;
            CH_MINUS: opc = OP_SUB;
            CH_STAR:  opc = OP_MUL;
            CH_SLASH: opc = OP_DIV;
            default:  is_op = 1'b0;
        endcase
    end

    assign is_digit = (i_char.char_code >= CH_ZERO) && (i_char.char_code <= CH_NINE);
    assign is_point = (i_char.char_code == CH_POINT);
    assign dig      = 4'(i_char.char_code - CH_ZERO);

    // acc * 10 + d
    assign int_nx  = (IW+4)'({r_int, 3'b000}) + (IW+4)'({r_int, 1'b0}) + (IW+4)'(dig);
    assign frac_nx = (FDW+4)'({r_frac, 3'b000}) + (FDW+4)'({r_frac, 1'b0}) + (FDW+4)'(dig);

    // Fraction: (d * 2^F + p/2) / p, and the total with saturation
    assign pw       = DVW'(pow10(int'(r_fcnt)));
    assign frac_num = (NW'(r_frac) << FRAC_BITS) + NW'(pw >> 1);
    assign fpart    = (r_fcnt != '0) ? W'(alu_res) : '0;
    assign total    = {2'b00, r_int, {FRAC_BITS{1'b0}}} + {1'b0, fpart};

    assign vm1 = r_vcnt - CW'(1);
    assign vm2 = r_vcnt - CW'(2);
    assign om1 = r_ocnt - CW'(1);

    assign op_b = (r_vcnt >= CW'(1)) ? r_rd_b : '0;
    assign op_a = (r_vcnt >= CW'(2)) ? r_rd_a : '0;
    assign vcnt_pop = (r_vcnt >= CW'(2)) ? vm2 : '0;

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_vcnt       = r_vcnt;
        n_ocnt       = r_ocnt;
        n_int        = r_int;
        n_frac       = r_frac;
        n_fcnt       = r_fcnt;
        n_point      = r_point;
        n_after_op   = r_after_op;
        n_err        = r_err;
        n_last       = r_last;
        n_final      = r_final;
        n_pend_op    = r_pend_op;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        v_we         = 1'b0;
        v_waddr      = r_vcnt[AW-1:0];
        v_wdata      = '0;
        o_we         = 1'b0;
        o_waddr      = r_ocnt[AW-1:0];
        alu_req      = '{start: 1'b0, cmd: CMD_ADD};
        alu_a        = '0;
        alu_b        = '0;
        err_t        = r_err;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_last = i_char.last_char;
                    if (r_err == ST_OK) begin
                        if (is_op) begin
                            if (r_after_op) begin
                                err_t = (r_vcnt == '0) ? ST_LEADING : ST_DOUBLE;
                            end
                        end else if (is_digit) begin
                            if (!r_point) begin
                                n_int = (int_nx[IW+3:IW] != '0) ? {IW{1'b1}} : int_nx[IW-1:0];
                            end else if (r_fcnt < FCW'(MAX_FRACTION_DIGITS)) begin
                                n_frac = frac_nx[FDW-1:0];
                                n_fcnt = r_fcnt + FCW'(1);
                            end
                            n_after_op = 1'b0;
                        end else if (is_point) begin
                            n_point    = 1'b1;
                            n_after_op = 1'b0;
                        end
                    end
                    n_err = err_t;
                    if (r_err == ST_OK && is_op && !r_after_op) begin
                        n_pend_op = opc;
                        n_final   = 1'b0;
                        n_state   = S_NUM;
                    end else if (i_char.last_char) begin
                        if (err_t != ST_OK) begin
                            n_state = S_FIN;
                        end else if (n_after_op) begin
                            n_err   = ST_TRAILING;
                            n_state = S_FIN;
                        end else begin
                            n_final = 1'b1;
                            n_state = S_NUM;
                        end
                    end
                end
            end
            S_NUM: begin
                alu_req = '{start: (r_fcnt != '0), cmd: CMD_FDIV};
                n_state = S_NUMW;
            end
            S_NUMW: begin
                // push the finished number
                if (r_fcnt == '0 || alu_done) begin
                    if (r_vcnt >= CW'(STACK_DEPTH)) begin
                        if (r_err == ST_OK) begin
                            n_err = ST_OVERFLOW;
                        end
                    end else begin
                        v_we    = 1'b1;
                        v_wdata = (total[W] || total[W-1]) ? {1'b0, {(W-1){1'b1}}}
                                                           : total[W-1:0];
                        n_vcnt  = r_vcnt + CW'(1);
                    end
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_TEST;
            end
            S_TEST: begin
                if (r_err != ST_OK || r_ocnt == '0 || (!r_final && r_pend_op > r_rd_op)) begin
                    n_state = r_final ? S_FIN : S_PUSHOP;
                end else begin
                    n_ocnt = om1;
                    n_vcnt = vcnt_pop;
                    alu_a  = op_a;
                    alu_b  = op_b;
                    if (r_rd_op == OP_DIV && op_b == '0) begin
                        n_err   = ST_DIVZERO;
                        v_we    = 1'b1;
                        v_waddr = vcnt_pop[AW-1:0];
                        v_wdata = '0;
                        n_vcnt  = vcnt_pop + CW'(1);
                        n_state = S_RD;
                    end else begin
                        case (r_rd_op)
                            OP_ADD:  alu_req = '{start: 1'b1, cmd: CMD_ADD};
                            OP_SUB:  alu_req = '{start: 1'b1, cmd: CMD_SUB};
                            OP_MUL:  alu_req = '{start: 1'b1, cmd: CMD_MUL};
                            default: alu_req = '{start: 1'b1, cmd: CMD_DIV};
                        endcase
                        n_state = S_OPW;
                    end
                end
            end
            S_OPW: begin
                if (alu_done) begin
                    v_we    = 1'b1;
                    v_wdata = alu_res;
                    n_vcnt  = r_vcnt + CW'(1);
                    n_state = S_RD;
                end
            end
            S_PUSHOP: begin
                if (r_ocnt >= CW'(STACK_DEPTH)) begin
                    if (r_err == ST_OK) begin
                        err_t = ST_OVERFLOW;
                    end
                end else begin
                    o_we   = 1'b1;
                    n_ocnt = r_ocnt + CW'(1);
                end
                n_int      = '0;
                n_frac     = '0;
                n_fcnt     = '0;
                n_point    = 1'b0;
                n_after_op = 1'b1;
                n_err      = err_t;
                if (r_last) begin
                    if (err_t == ST_OK) begin
                        n_err = ST_TRAILING;
                    end
                    n_state = S_FIN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FIN: begin
                n_out_value  = (r_err == ST_OK && r_vcnt != '0) ? r_rd_b : '0;
                n_out_status = r_err;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (o_result.ready) begin
                    n_vcnt     = '0;
                    n_ocnt     = '0;
                    n_int      = '0;
                    n_frac     = '0;
                    n_fcnt     = '0;
                    n_point    = 1'b0;
                    n_after_op = 1'b1;
                    n_err      = ST_OK;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    iee_alu #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .NUM_WIDTH   (NW),
        .DEN_WIDTH   (DVW)
    ) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_op_a   (alu_a),
        .i_op_b   (alu_b),
        .i_num    (frac_num),
        .i_den    (pw),
        .o_done   (alu_done),
        .o_result (alu_res)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_vcnt     <= '0;
            r_ocnt     <= '0;
            r_int      <= '0;
            r_frac     <= '0;
            r_fcnt     <= '0;
            r_point    <= 1'b0;
            r_after_op <= 1'b1;
            r_err      <= ST_OK;
            r_last     <= 1'b0;
            r_final    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_vcnt     <= n_vcnt;
            r_ocnt     <= n_ocnt;
            r_int      <= n_int;
            r_frac     <= n_frac;
            r_fcnt     <= n_fcnt;
            r_point    <= n_point;
            r_after_op <= n_after_op;
            r_err      <= n_err;
            r_last     <= n_last;
            r_final    <= n_final;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_op    <= n_pend_op;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    // Value stack: one write port, two registered read ports at the top
    always_ff @(posedge i_clk) begin
        if (v_we) begin
            r_vmem[v_waddr] <= v_wdata;
        end
        r_rd_b <= r_vmem[vm1[AW-1:0]];
        r_rd_a <= r_vmem[vm2[AW-1:0]];
    end

    // Operator stack
    always_ff @(posedge i_clk) begin
        if (o_we) begin
            r_omem[o_waddr] <= r_pend_op;
        end
        r_rd_op <= r_omem[om1[AW-1:0]];
    end

    assign i_char.ready          = (r_state == S_IDLE);
    assign o_result.valid        = (r_state == S_OUT);
    assign o_result.result_value = r_out_value;
    assign o_result.status       = r_out_status;

    // Checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vcnt <= CW'(STACK_DEPTH)) && (r_ocnt <= CW'(STACK_DEPTH)))
        else $error("stack count beyond depth");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.status != ST_OK) |-> (o_result.result_value == '0))
        else $error("nonzero value with error status");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.ready) |=>
            (r_vcnt == '0 && r_ocnt == '0 && r_after_op && r_err == ST_OK))
        else $error("state not cleared after result transfer");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> !i_char.ready)
        else $error("input ready while result pending");

endmodule

### rtl/core/iee_alu.sv
module iee_alu
    import iee_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int NUM_WIDTH   = DEF_VALUE_WIDTH + DEF_FRAC_BITS,
    parameter int DEN_WIDTH   = DEF_VALUE_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_alu_req                      i_req,
    input  logic signed [VALUE_WIDTH-1:0] i_op_a,
    input  logic signed [VALUE_WIDTH-1:0] i_op_b,
    input  logic [NUM_WIDTH-1:0]          i_num,
    input  logic [DEN_WIDTH-1:0]          i_den,
    output logic                          o_done,
    output logic signed [VALUE_WIDTH-1:0] o_result
);

    localparam int W    = VALUE_WIDTH;
    localparam int PW   = 2 * W - FRAC_BITS;
    localparam int XW   = (PW > NUM_WIDTH) ? PW : NUM_WIDTH;
    localparam int STPS = (NUM_WIDTH > W) ? NUM_WIDTH : W;
    localparam int CNTW = $clog2(STPS + 1);

    typedef enum logic [4:0] {
        A_IDLE = 5'b00001,
        A_MUL  = 5'b00010,
        A_DIV  = 5'b00100,
        A_SAT  = 5'b01000,
        A_DONE = 5'b10000
    } t_alu_state;

    t_alu_state            r_state, n_state;
    logic [CNTW-1:0]       r_cnt, n_cnt;
    t_alu_cmd              r_cmd, n_cmd;
    logic                  r_neg, n_neg;
    logic [W-1:0]          r_phi, n_phi;
    logic [W-1:0]          r_plo, n_plo;
    logic [W-1:0]          r_ma, n_ma;
    logic [NUM_WIDTH-1:0]  r_num, n_num;
    logic [DEN_WIDTH-1:0]  r_den, n_den;
    logic [DEN_WIDTH-1:0]  r_rem, n_rem;
    logic signed [W-1:0]   r_res, n_res;

    logic [W-1:0]          mag_a, mag_b;
    logic [W:0]            add_s;
    logic [W:0]            mul_s;
    logic [DEN_WIDTH:0]    div_rs, div_diff;
    logic                  div_ge;
    logic [XW-1:0]         sat_mag, sat_lim, sat_m;
    logic [2*W-1:0]        prod;

    assign mag_a = i_op_a[W-1] ? W'(-i_op_a) : W'(i_op_a);
    assign mag_b = i_op_b[W-1] ? W'(-i_op_b) : W'(i_op_b);

    // Shift-add multiply step
    assign mul_s = {1'b0, r_phi} + (r_plo[0] ? {1'b0, r_ma} : {(W+1){1'b0}});

    // Restoring divide step
    assign div_rs   = {r_rem, r_num[NUM_WIDTH-1]};
    assign div_ge   = div_rs >= {1'b0, r_den};
    assign div_diff = div_rs - {1'b0, r_den};

    assign prod = {r_phi, r_plo};

    // Magnitude saturation
    always_comb begin
        if (r_cmd == CMD_MUL) begin
            sat_mag = XW'(prod[2*W-1:FRAC_BITS]);
        end else begin
            sat_mag = XW'(r_num);
        end
        sat_lim = r_neg ? (XW'(1) << (W - 1)) : ((XW'(1) << (W - 1)) - XW'(1));
        sat_m   = (sat_mag > sat_lim) ? sat_lim : sat_mag;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_cmd   = r_cmd;
        n_neg   = r_neg;
        n_phi   = r_phi;
        n_plo   = r_plo;
        n_ma    = r_ma;
        n_num   = r_num;
        n_den   = r_den;
        n_rem   = r_rem;
        n_res   = r_res;
        add_s   = '0;
        case (r_state)
            A_IDLE: begin
                if (i_req.start) begin
                    n_cmd = i_req.cmd;
                    n_neg = i_op_a[W-1] ^ i_op_b[W-1];
                    case (i_req.cmd)
                        CMD_ADD, CMD_SUB: begin
                            if (i_req.cmd == CMD_ADD) begin
                                add_s = {i_op_a[W-1], i_op_a} + {i_op_b[W-1], i_op_b};
                            end else begin
                                add_s = {i_op_a[W-1], i_op_a} - {i_op_b[W-1], i_op_b};
                            end
                            if (add_s[W] != add_s[W-1]) begin
                                n_res = add_s[W] ? {1'b1, {(W-1){1'b0}}}
                                                 : {1'b0, {(W-1){1'b1}}};
                            end else begin
                                n_res = add_s[W-1:0];
                            end
                            n_state = A_DONE;
                        end
                        CMD_MUL: begin
                            n_ma    = mag_a;
                            n_plo   = mag_b;
                            n_phi   = '0;
                            n_cnt   = CNTW'(W);
                            n_state = A_MUL;
                        end
                        CMD_DIV: begin
                            n_num   = NUM_WIDTH'(mag_a) << FRAC_BITS;
                            n_den   = DEN_WIDTH'(mag_b);
                            n_rem   = '0;
                            n_cnt   = CNTW'(NUM_WIDTH);
                            n_state = A_DIV;
                        end
                        CMD_FDIV: begin
                            n_num   = i_num;
                            n_den   = i_den;
                            n_rem   = '0;
                            n_neg   = 1'b0;
                            n_cnt   = CNTW'(NUM_WIDTH);
                            n_state = A_DIV;
                        end
                        default: n_state = A_IDLE;
                    endcase
                end
            end
            A_MUL: begin
                n_phi = mul_s[W:1];
                n_plo = {mul_s[0], r_plo[W-1:1]};
                n_cnt = r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    n_state = A_SAT;
                end
            end
            A_DIV: begin
                n_rem = div_ge ? div_diff[DEN_WIDTH-1:0] : div_rs[DEN_WIDTH-1:0];
                n_num = {r_num[NUM_WIDTH-2:0], div_ge};
                n_cnt = r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    n_state = A_SAT;
                end
            end
            A_SAT: begin
                if (r_cmd == CMD_FDIV) begin
                    n_res = W'(r_num);
                end else if (r_neg) begin
                    n_res = -W'(sat_m);
                end else begin
                    n_res = W'(sat_m);
                end
                n_state = A_DONE;
            end
            A_DONE: begin
                n_state = A_IDLE;
            end
            default: n_state = A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_neg <= n_neg;
        r_phi <= n_phi;
        r_plo <= n_plo;
        r_ma  <= n_ma;
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
        r_res <= n_res;
    end

    assign o_done   = (r_state == A_DONE);
    assign o_result = r_res;

endmodule
